// ----- sv/pta_pkg.sv -----
// Shared types and constants for the peer table with aging.
// Request and result payloads, table entry layout, event and register codes.
// No dependencies.
package pta_pkg;

	localparam int TABLE_DEPTH_DEF = 16;
	localparam int MAX_EVENTS      = 16;

	localparam logic [1:0] EV_ADD  = 2'd0;
	localparam logic [1:0] EV_DEL  = 2'd1;
	localparam logic [1:0] EV_FULL = 2'd2;

	localparam logic [1:0] CFG_REPLY_CODE = 2'd0;
	localparam logic [1:0] CFG_MAX_AGE    = 2'd1;

	localparam logic [7:0]  REPLY_CODE_RST = 8'd1;
	localparam logic [31:0] MAX_AGE_RST    = 32'd5000;

	typedef struct packed {
		logic        func;
		logic [7:0]  response_code;
		logic [31:0] host;
		logic [31:0] sender_host;
		logic [15:0] port;
		logic [15:0] elapsed;
	} req_t;

	typedef struct packed {
		logic [1:0]  event_res;
		logic [3:0]  slot;
		logic [31:0] peer_host;
		logic [15:0] peer_port;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [31:0] host;
		logic [15:0] port;
		logic [31:0] age;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_ADD,
		ST_FLUSH
	} state_t;

endpackage

// ----- sv/pta_ram.sv -----
// Synchronous table memory: one write port, one read port, registered read data.
// Depends on pta_pkg for default sizes.
module pta_ram #(
	parameter int DEPTH = pta_pkg::TABLE_DEPTH_DEF,
	parameter int WIDTH = $bits(pta_pkg::entry_t),
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/peer_table_with_aging.sv -----
// Peer table with aging: top level with the slot walker and configuration registers.
// Depends on pta_pkg and pta_ram.
//
// Each request walks the slots of the table memory, a read state and then an
// evaluate and write-back state per slot, because the memory has registered read
// data and one port each way. A tick walks every slot from the highest down; a
// reply walks up from slot 0 and then adds the peer or reports the table full,
// but ends early when it finds a known peer in some slot. A reply that fails the
// code check is dropped without a walk. A stall on the result side can hold the
// walk. Valid bits are flip-flops cleared by reset, so no clearing pass is
// needed. Deletions on a tick are reported from the highest slot down, at most
// sixteen per tick.
module peer_table_with_aging #(
	parameter int TABLE_DEPTH = pta_pkg::TABLE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [31:0]   cfg_data,
	input  logic          req_valid,
	output logic          req_stall,
	input  pta_pkg::req_t req,
	output logic          res_valid,
	input  logic          res_stall,
	output pta_pkg::res_t res
);

	localparam int SLOT_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = $clog2(pta_pkg::MAX_EVENTS + 1);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(TABLE_DEPTH - 1);

	pta_pkg::state_t state_q, state_d;
	logic [SLOT_W-1:0] idx_q, idx_d;
	logic [SLOT_W-1:0] free_q, free_d;
	logic              free_v_q, free_v_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              pend_v_q, pend_v_d;
	pta_pkg::res_t     pend_q, pend_d;
	logic              res_v_q, res_v_d;
	pta_pkg::res_t     res_q, res_d;
	logic [TABLE_DEPTH-1:0] valid_q, valid_d;
	logic              func_q, func_d;
	logic [31:0]       host_q, host_d;
	logic [15:0]       port_q, port_d;
	logic [15:0]       elapsed_q, elapsed_d;
	logic [7:0]        reply_code_q;
	logic [31:0]       max_age_q;

	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	pta_pkg::entry_t   mem_wdata;
	logic              mem_re;
	pta_pkg::entry_t   rd_entry;

	logic [32:0]       age_sum;
	logic [31:0]       age_new;
	logic              res_free;
	logic              hit_del;
	logic              key_match;

	pta_ram #(
		.DEPTH(TABLE_DEPTH),
		.WIDTH($bits(pta_pkg::entry_t))
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(idx_q),
		.rdata(rd_entry)
	);

	assign cfg_ready = 1'b1;
	assign req_stall = (state_q != pta_pkg::ST_IDLE);
	assign res_valid = res_v_q;
	assign res       = res_q;
	assign res_free  = !res_v_q || !res_stall;

	assign age_sum   = {1'b0, rd_entry.age} + 33'(elapsed_q);
	assign age_new   = age_sum[32] ? 32'hFFFF_FFFF : age_sum[31:0];
	assign key_match = valid_q[idx_q] && (rd_entry.host == host_q)
		&& (rd_entry.port == port_q);
	assign hit_del   = valid_q[idx_q] && (age_new > max_age_q)
		&& (cnt_q < CNT_W'(pta_pkg::MAX_EVENTS));

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		free_d    = free_q;
		free_v_d  = free_v_q;
		cnt_d     = cnt_q;
		pend_v_d  = pend_v_q;
		pend_d    = pend_q;
		valid_d   = valid_q;
		func_d    = func_q;
		host_d    = host_q;
		port_d    = port_q;
		elapsed_d = elapsed_q;
		res_v_d   = res_v_q && res_stall;
		res_d     = res_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = rd_entry;
		mem_re    = 1'b0;
		unique case (state_q)
			pta_pkg::ST_IDLE: begin
				if (req_valid) begin
					func_d    = req.func;
					host_d    = (req.host == 32'd0) ? req.sender_host : req.host;
					port_d    = req.port;
					elapsed_d = req.elapsed;
					free_v_d  = 1'b0;
					cnt_d     = '0;
					idx_d     = req.func ? SLOT_LAST : '0;
					if (req.func || req.response_code == reply_code_q) begin
						state_d = pta_pkg::ST_READ;
					end
				end
			end
			pta_pkg::ST_READ: begin
				mem_re  = 1'b1;
				state_d = pta_pkg::ST_EVAL;
			end
			pta_pkg::ST_EVAL: begin
				if (!func_q) begin
					if (key_match) begin
						mem_we        = 1'b1;
						mem_wdata.age = '0;
						state_d       = pta_pkg::ST_IDLE;
					end else begin
						if (!valid_q[idx_q] && !free_v_q) begin
							free_v_d = 1'b1;
							free_d   = idx_q;
						end
						if (idx_q == SLOT_LAST) begin
							state_d = pta_pkg::ST_ADD;
						end else begin
							idx_d   = idx_q + 1'b1;
							state_d = pta_pkg::ST_READ;
						end
					end
				end else if (!(hit_del && pend_v_q && !res_free)) begin
					if (valid_q[idx_q]) begin
						mem_we        = 1'b1;
						mem_wdata.age = age_new;
					end
					if (hit_del) begin
						valid_d[idx_q] = 1'b0;
						cnt_d          = cnt_q + 1'b1;
						if (pend_v_q) begin
							res_v_d = 1'b1;
							res_d   = pend_q;
						end
						pend_v_d = 1'b1;
						pend_d   = '{event_res: pta_pkg::EV_DEL, slot: 4'(idx_q),
							peer_host: rd_entry.host, peer_port: rd_entry.port,
							last: 1'b0};
					end
					if (idx_q == '0) begin
						state_d = pta_pkg::ST_FLUSH;
					end else begin
						idx_d   = idx_q - 1'b1;
						state_d = pta_pkg::ST_READ;
					end
				end
			end
			pta_pkg::ST_ADD: begin
				pend_v_d = 1'b1;
				if (free_v_q) begin
					mem_we            = 1'b1;
					mem_waddr         = free_q;
					mem_wdata         = '{host: host_q, port: port_q, age: 32'd0};
					valid_d[free_q]   = 1'b1;
					pend_d = '{event_res: pta_pkg::EV_ADD, slot: 4'(free_q),
						peer_host: host_q, peer_port: port_q, last: 1'b0};
				end else begin
					pend_d = '{event_res: pta_pkg::EV_FULL, slot: 4'd0,
						peer_host: host_q, peer_port: port_q, last: 1'b0};
				end
				state_d = pta_pkg::ST_FLUSH;
			end
			pta_pkg::ST_FLUSH: begin
				if (!pend_v_q) begin
					state_d = pta_pkg::ST_IDLE;
				end else if (res_free) begin
					res_v_d    = 1'b1;
					res_d      = pend_q;
					res_d.last = 1'b1;
					pend_v_d   = 1'b0;
					state_d    = pta_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pta_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pta_pkg::ST_IDLE;
			idx_q        <= '0;
			free_v_q     <= 1'b0;
			cnt_q        <= '0;
			pend_v_q     <= 1'b0;
			res_v_q      <= 1'b0;
			valid_q      <= '0;
			reply_code_q <= pta_pkg::REPLY_CODE_RST;
			max_age_q    <= pta_pkg::MAX_AGE_RST;
		end else begin
			state_q  <= state_d;
			idx_q    <= idx_d;
			free_v_q <= free_v_d;
			cnt_q    <= cnt_d;
			pend_v_q <= pend_v_d;
			res_v_q  <= res_v_d;
			valid_q  <= valid_d;
			if (cfg_valid) begin
				unique case (cfg_index)
					pta_pkg::CFG_REPLY_CODE: reply_code_q <= cfg_data[7:0];
					pta_pkg::CFG_MAX_AGE:    max_age_q    <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		free_q    <= free_d;
		pend_q    <= pend_d;
		res_q     <= res_d;
		func_q    <= func_d;
		host_q    <= host_d;
		port_q    <= port_d;
		elapsed_q <= elapsed_d;
	end

endmodule
